// ===== design/rwba_pkg.sv =====
`default_nettype none
package rwba_pkg;

    // fixed widths of the register file and the accumulator store
    localparam int SUM_W     = 56;
    localparam int CNT_W     = 9;
    localparam int FIELD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int SCALE_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int MAX_ROWS  = 4096;
    localparam int Q_DEPTH   = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINE_COLS  = 3'd0,
        CFG_FINE_ROWS  = 3'd1,
        CFG_SCALE      = 3'd2,
        CFG_RANGE_LOW  = 3'd3,
        CFG_RANGE_HIGH = 3'd4,
        CFG_MIN_VALID  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   fine_cols;
        logic [DIM_W-1:0]   fine_rows;
        logic [SCALE_W-1:0] block_scale;
        logic [11:0]        range_low;
        logic [11:0]        range_high;
        logic [CNT_W-1:0]   min_valid_count;
    } t_cfg;

    // one finished block, handed from front to back
    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   cnt;
        logic               last;
    } t_blk;

endpackage
`default_nettype wire

// ===== design/radiance_weighted_block_aggregate_top.sv =====
`default_nettype none
// Fourth-power-mean block downsampler. Fine pixels enter in raster order; the
// front end takes one pixel at a time (capture, store read and square, fourth
// power, store write) and keeps per-column sums and valid counts in a store one
// entry per coarse column. Each finished block passes through a 4-entry queue to
// the back end, which runs a bit-serial divide and a 12-bit root search (square,
// fourth power, compare per root bit) for an aggregated block and skips both for
// a fill block. The front end stalls at a finished block while the queue is
// full, the back end while the output is not taken. The accumulator store is
// not cleared at reset; every block overwrites its entry at its first pixel.
module radiance_weighted_block_aggregate_top #(
    parameter int MAX_FINE_COLS = 4096,
    parameter int MAX_SCALE     = 16,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rwba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rwba_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [SAMPLE_BITS-1:0]             i_temperature,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [11:0]                             o_coarse_row,
    output logic [11:0]                             o_coarse_col,
    output logic [11:0]                             o_coarse_temperature,
    output logic                                    o_aggregated,
    output logic                                    o_last_of_image
);

    rwba_pkg::t_cfg r_cfg;
    rwba_pkg::t_blk w_push_blk, w_pop_blk;
    logic w_push, w_pop, w_full, w_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_cols       <= 13'd4096;
            r_cfg.fine_rows       <= 13'd4096;
            r_cfg.block_scale     <= 5'd2;
            r_cfg.range_low       <= 12'd0;
            r_cfg.range_high      <= 12'd4095;
            r_cfg.min_valid_count <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rwba_pkg::CFG_FINE_COLS:  r_cfg.fine_cols       <= i_cfg_data;
                rwba_pkg::CFG_FINE_ROWS:  r_cfg.fine_rows       <= i_cfg_data;
                rwba_pkg::CFG_SCALE:      r_cfg.block_scale     <= i_cfg_data[4:0];
                rwba_pkg::CFG_RANGE_LOW:  r_cfg.range_low       <= i_cfg_data[11:0];
                rwba_pkg::CFG_RANGE_HIGH: r_cfg.range_high      <= i_cfg_data[11:0];
                rwba_pkg::CFG_MIN_VALID:  r_cfg.min_valid_count <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    rwba_front #(
        .MAX_FINE_COLS(MAX_FINE_COLS),
        .MAX_SCALE    (MAX_SCALE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_temperature(i_temperature),
        .o_push       (w_push),
        .o_blk        (w_push_blk),
        .i_q_full     (w_full)
    );

    rwba_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_blk),
        .i_pop  (w_pop),
        .o_data (w_pop_blk),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    rwba_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_min_valid         (r_cfg.min_valid_count),
        .i_blk               (w_pop_blk),
        .i_empty             (w_empty),
        .o_pop               (w_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_coarse_row        (o_coarse_row),
        .o_coarse_col        (o_coarse_col),
        .o_coarse_temperature(o_coarse_temperature),
        .o_aggregated        (o_aggregated),
        .o_last_of_image     (o_last_of_image)
    );

    // queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue overflow");

    // front end works on one pixel at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("pixel accepted while busy");

    // fill blocks carry a zero temperature
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_aggregated) |-> (o_coarse_temperature == 12'd0))
        else $error("fill block with nonzero temperature");

endmodule
`default_nettype wire

// ===== design/rwba_front.sv =====
`default_nettype none
module rwba_front #(
    parameter int MAX_FINE_COLS = 4096,
    parameter int MAX_SCALE     = 16,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rwba_pkg::t_cfg         i_cfg,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_temperature,
    output logic                        o_push,
    output rwba_pkg::t_blk              o_blk,
    input  wire logic                   i_q_full
);

    localparam int COLW = (MAX_FINE_COLS > 1) ? $clog2(MAX_FINE_COLS) : 1;
    localparam int CLW  = $clog2(MAX_FINE_COLS + 1);
    localparam int DW   = (CLW > rwba_pkg::DIM_W) ? CLW : rwba_pkg::DIM_W;
    localparam int SCW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SSW  = SCW + 1;
    localparam int P2W  = 2 * SAMPLE_BITS;
    localparam int P4W  = 4 * SAMPLE_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_P4, S_WR} t_state;

    t_state r_state;
    logic [COLW-1:0] r_col;
    logic [11:0]     r_row;
    logic [SCW-1:0]  r_cwb, r_rwb;

    // captured transaction
    logic [SAMPLE_BITS-1:0] r_t;
    logic                   r_inrange, r_start, r_done, r_last;
    logic [COLW-1:0]        r_slot;
    logic [11:0]            r_orow, r_ocol;
    logic [P2W-1:0]         r_p2;
    logic [P4W-1:0]         r_p4;
    logic [rwba_pkg::SUM_W-1:0] r_rd_sum;
    logic [rwba_pkg::CNT_W-1:0] r_rd_cnt;

    // per-column accumulator store
    logic [rwba_pkg::SUM_W-1:0] r_sum_mem [MAX_FINE_COLS];
    logic [rwba_pkg::CNT_W-1:0] r_cnt_mem [MAX_FINE_COLS];

    logic [DW-1:0]                cols;
    logic [rwba_pkg::DIM_W-1:0]   rows;
    logic [SSW-1:0]               scale;
    logic line_end, image_end, col_done, row_done, accept;
    logic [rwba_pkg::SUM_W-1:0] n_sum;
    logic [rwba_pkg::CNT_W-1:0] n_cnt, base_cnt;
    logic [19:0]                recip;
    logic [COLW+19:0]           col_prod;
    logic [31:0]                row_prod;
    logic [COLW-1:0]            ccol;
    logic [11:0]                crow;

    // geometry with out-of-range values clamped
    always_comb begin
        if (i_cfg.fine_cols == '0) begin
            cols = DW'(1);
        end else if (DW'(i_cfg.fine_cols) > DW'(MAX_FINE_COLS)) begin
            cols = DW'(MAX_FINE_COLS);
        end else begin
            cols = DW'(i_cfg.fine_cols);
        end
        if (i_cfg.fine_rows == '0) begin
            rows = rwba_pkg::DIM_W'(1);
        end else if (i_cfg.fine_rows > rwba_pkg::DIM_W'(rwba_pkg::MAX_ROWS)) begin
            rows = rwba_pkg::DIM_W'(rwba_pkg::MAX_ROWS);
        end else begin
            rows = i_cfg.fine_rows;
        end
        if (i_cfg.block_scale == '0) begin
            scale = SSW'(1);
        end else if (i_cfg.block_scale > rwba_pkg::SCALE_W'(MAX_SCALE)) begin
            scale = SSW'(MAX_SCALE);
        end else begin
            scale = SSW'(i_cfg.block_scale);
        end
    end

    // ceil(2^19 / scale): exact floor division of any column or row index
    always_comb begin
        unique case (5'(scale))
            5'd1:    recip = 20'd524288;
            5'd2:    recip = 20'd262144;
            5'd3:    recip = 20'd174763;
            5'd4:    recip = 20'd131072;
            5'd5:    recip = 20'd104858;
            5'd6:    recip = 20'd87382;
            5'd7:    recip = 20'd74899;
            5'd8:    recip = 20'd65536;
            5'd9:    recip = 20'd58255;
            5'd10:   recip = 20'd52429;
            5'd11:   recip = 20'd47663;
            5'd12:   recip = 20'd43691;
            5'd13:   recip = 20'd40330;
            5'd14:   recip = 20'd37450;
            5'd15:   recip = 20'd34953;
            5'd16:   recip = 20'd32768;
            default: recip = '0;
        endcase
    end

    // coarse position of the current pixel
    assign col_prod = (COLW+20)'(r_col) * (COLW+20)'(recip);
    assign row_prod = 32'(r_row) * 32'(recip);
    assign ccol     = col_prod[COLW+18:19];
    assign crow     = row_prod[30:19];

    // raster position classification
    assign line_end  = (DW'(r_col) + DW'(1)) >= cols;
    assign image_end = (rwba_pkg::DIM_W'(r_row) + rwba_pkg::DIM_W'(1)) >= rows;
    assign col_done  = line_end || ((SSW'(r_cwb) + SSW'(1)) >= scale);
    assign row_done  = image_end || ((SSW'(r_rwb) + SSW'(1)) >= scale);

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    // accumulate: restart at block start, add only in-range pixels, count saturates
    always_comb begin
        base_cnt = r_start ? '0 : r_rd_cnt;
        n_sum    = (r_start ? '0 : r_rd_sum)
                 + (r_inrange ? rwba_pkg::SUM_W'(r_p4) : '0);
        n_cnt    = (r_inrange && (base_cnt != rwba_pkg::CNT_MAX))
                 ? base_cnt + rwba_pkg::CNT_W'(1) : base_cnt;
    end

    assign o_push = (r_state == S_WR) && r_done && !i_q_full;
    assign o_blk  = '{row: r_orow, col: r_ocol, sum: n_sum, cnt: n_cnt, last: r_last};

    // sequencer and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_cwb   <= '0;
            r_rwb   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SQ;
                        if (line_end) begin
                            r_col  <= '0;
                            r_cwb  <= '0;
                            if (image_end) begin
                                r_row  <= '0;
                                r_rwb  <= '0;
                            end else begin
                                r_row <= r_row + 12'd1;
                                if (row_done) begin
                                    r_rwb  <= '0;
                                end else begin
                                    r_rwb <= r_rwb + SCW'(1);
                                end
                            end
                        end else begin
                            r_col <= r_col + COLW'(1);
                            if (col_done) begin
                                r_cwb  <= '0;
                            end else begin
                                r_cwb <= r_cwb + SCW'(1);
                            end
                        end
                    end
                end
                S_SQ: r_state <= S_P4;
                S_P4: r_state <= S_WR;
                S_WR: begin
                    if (!r_done || !i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: capture, fourth power, store read-modify-write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t       <= i_temperature;
            r_inrange <= (12'(i_temperature) >= i_cfg.range_low)
                      && (12'(i_temperature) <= i_cfg.range_high);
            r_start   <= (r_rwb == '0) && (r_cwb == '0);
            r_slot    <= ccol;
            r_done    <= col_done && row_done;
            r_last    <= line_end && image_end;
            r_orow    <= crow;
            r_ocol    <= 12'(ccol);
        end
        if (r_state == S_SQ) begin
            r_p2     <= P2W'(r_t) * P2W'(r_t);
            r_rd_sum <= r_sum_mem[r_slot];
            r_rd_cnt <= r_cnt_mem[r_slot];
        end
        if (r_state == S_P4) begin
            r_p4 <= P4W'(r_p2) * P4W'(r_p2);
        end
        if (r_state == S_WR) begin
            r_sum_mem[r_slot] <= n_sum;
            r_cnt_mem[r_slot] <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== design/rwba_queue.sv =====
`default_nettype none
module rwba_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rwba_pkg::t_blk i_data,
    input  wire logic           i_pop,
    output rwba_pkg::t_blk      o_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PW = $clog2(rwba_pkg::Q_DEPTH);

    rwba_pkg::t_blk r_mem [rwba_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_fill;

    assign o_full  = (r_fill == (PW+1)'(rwba_pkg::Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            r_fill <= r_fill + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

// ===== design/rwba_back.sv =====
`default_nettype none
module rwba_back #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [rwba_pkg::CNT_W-1:0]   i_min_valid,
    input  wire rwba_pkg::t_blk               i_blk,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [11:0]                       o_coarse_row,
    output logic [11:0]                       o_coarse_col,
    output logic [11:0]                       o_coarse_temperature,
    output logic                              o_aggregated,
    output logic                              o_last_of_image
);

    localparam int SUM_W = rwba_pkg::SUM_W;
    localparam int CNT_W = rwba_pkg::CNT_W;
    localparam int DCW   = $clog2(SUM_W);
    localparam int BW    = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;
    localparam int P2W   = 2 * SAMPLE_BITS;
    localparam int P4W   = 4 * SAMPLE_BITS;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_SQ, B_Q4, B_CMP, B_OUT} t_state;

    t_state r_state;
    logic [11:0]            r_row, r_col;
    logic                   r_agg, r_last;
    logic [SUM_W-1:0]       r_dvd;
    logic [CNT_W-1:0]       r_den, r_rem;
    logic [DCW-1:0]         r_step;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [BW-1:0]          r_bit;
    logic [P2W-1:0]         r_sq;
    logic [P4W-1:0]         r_q4;

    logic [CNT_W:0]         rem_sh;
    logic                   q_bit;
    logic [SAMPLE_BITS-1:0] cand;

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};
    // trial root for the current bit
    assign cand   = r_root | (SAMPLE_BITS'(1) << r_bit);

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = (r_state == B_OUT);
    assign o_coarse_row         = r_row;
    assign o_coarse_col         = r_col;
    assign o_coarse_temperature = 12'(r_root);
    assign o_aggregated         = r_agg;
    assign o_last_of_image      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ((i_blk.cnt != '0) && (i_blk.cnt >= i_min_valid))
                                 ? B_DIV : B_OUT;
                    end
                end
                B_DIV: begin
                    if (r_step == DCW'(SUM_W - 1)) r_state <= B_SQ;
                end
                B_SQ:  r_state <= B_Q4;
                B_Q4:  r_state <= B_CMP;
                B_CMP: r_state <= (r_bit == '0) ? B_OUT : B_SQ;
                B_OUT: begin
                    if (i_ready) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // divider and root datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_row  <= i_blk.row;
                r_col  <= i_blk.col;
                r_last <= i_blk.last;
                r_agg  <= (i_blk.cnt != '0) && (i_blk.cnt >= i_min_valid);
                r_dvd  <= i_blk.sum;
                r_den  <= i_blk.cnt;
                r_rem  <= '0;
                r_step <= '0;
                r_root <= '0;
                r_bit  <= BW'(SAMPLE_BITS - 1);
            end
            B_DIV: begin
                r_rem  <= q_bit ? CNT_W'(rem_sh - {1'b0, r_den}) : CNT_W'(rem_sh);
                r_dvd  <= {r_dvd[SUM_W-2:0], q_bit};
                r_step <= r_step + DCW'(1);
            end
            B_SQ: r_sq <= P2W'(cand) * P2W'(cand);
            B_Q4: r_q4 <= P4W'(r_sq) * P4W'(r_sq);
            B_CMP: begin
                if (SUM_W'(r_q4) <= r_dvd) r_root <= cand;
                r_bit <= r_bit - BW'(1);
            end
            B_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
